@@ src/bsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Button sequence matcher package
// Shared constants, payload types and controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsm_pkg;

  localparam int DEF_HISTORY_DEPTH = 16;
  localparam int DEF_NUM_SEQUENCES = 8;
  localparam int DEF_MASK_WIDTH    = 16;

  localparam int SEQ_SLOTS = 16;
  localparam int SLOT_W    = $clog2(SEQ_SLOTS);
  localparam int LEN_W     = $clog2(SEQ_SLOTS + 1);
  localparam int IDX_W     = 3;

  localparam logic REQ_PRESS = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic        stream_idle;
    logic [15:0] button_mask;
    logic [2:0]  table_slot;
    logic [3:0]  table_position;
    logic [15:0] table_value;
  } bsm_in_t;

  typedef struct packed {
    logic             matched;
    logic [IDX_W-1:0] matched_index;
  } bsm_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEN,
    ST_CMP,
    ST_DONE
  } bsm_state_t;

endpackage

`default_nettype wire

@@ src/bsm_tbl_mem.sv @@
// ----------------------------------------------------------------------------
// Sequence table memory
// Single write port and single registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsm_tbl_mem import bsm_pkg::*; #(
  parameter int  DEPTH = DEF_NUM_SEQUENCES * SEQ_SLOTS,
  parameter int  WIDTH = DEF_MASK_WIDTH,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ src/bsm_hist_mem.sv @@
// ----------------------------------------------------------------------------
// Press history ring memory
// Ring storage with per-entry valid bits; an invalid entry reads as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsm_hist_mem import bsm_pkg::*; #(
  parameter int  DEPTH = DEF_HISTORY_DEPTH,
  parameter int  WIDTH = DEF_MASK_WIDTH,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             clr,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] vld_nxt;
  logic [WIDTH-1:0] rdata_r;
  logic             rvld_r;

  always_comb begin
    vld_nxt = vld_r;
    if (clr) begin
      vld_nxt = '0;
    end else if (we) begin
      vld_nxt[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      rvld_r <= vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

`default_nettype wire

@@ src/button_sequence_matcher_top.sv @@
// ----------------------------------------------------------------------------
// Button sequence matcher
// Matches recent button presses against a table of stored sequences.
// ----------------------------------------------------------------------------
// The in_ channel carries press and table write transactions; every input
// transaction produces exactly one out_ transaction. A table write or an
// ignored press goes from idle straight to the done state, from which its
// result is loaded into the output register. A counted press walks the
// sequences in index order over the single read port of the table memory,
// one word per cycle: for each sequence it reads words until an empty one
// or a full sequence of 16 to find the length, then compares up to that
// many words against the press history.
// One item is processed at a time; in_ready is high only while the block is
// idle. The result sits in an output register, so the next transaction may
// be accepted while a result is still stalled by out_ready; the following
// result then waits until the register is free.
// After reset the block sweeps the table memory to zero, one word per
// cycle; in_ready stays low during that sweep. The press history is
// cleared at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_sequence_matcher_top import bsm_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int NUM_SEQUENCES = DEF_NUM_SEQUENCES,
  parameter int MASK_WIDTH    = DEF_MASK_WIDTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire bsm_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output bsm_out_t      out_data
);

  localparam int TBL_DEPTH = NUM_SEQUENCES * SEQ_SLOTS;
  localparam int TA_W      = $clog2(TBL_DEPTH);
  localparam int HA_W      = $clog2(HISTORY_DEPTH);
  localparam int SEQ_W     = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;

  bsm_state_t       state_r, state_nxt;
  logic [TA_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [HA_W-1:0]  ptr_r, ptr_nxt;
  logic [HA_W-1:0]  pos_r, pos_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [SLOT_W-1:0] k_r, k_nxt;
  logic             res_matched_r, res_matched_nxt;
  logic [IDX_W-1:0] res_index_r, res_index_nxt;
  logic             out_valid_r, out_valid_nxt;
  bsm_out_t         out_data_r, out_data_nxt;

  logic [31:0]           mask_ext;
  logic [31:0]           value_ext;
  logic [MASK_WIDTH-1:0] press_mask;
  logic [MASK_WIDTH-1:0] table_word;
  logic                  in_fire;
  logic                  press_go;
  logic                  slot_ok;

  logic                  tbl_we;
  logic [TA_W-1:0]       tbl_waddr;
  logic [MASK_WIDTH-1:0] tbl_wdata;
  logic [TA_W-1:0]       tbl_raddr;
  logic [MASK_WIDTH-1:0] tbl_rdata;

  logic                  hist_clr;
  logic                  hist_we;
  logic [HA_W-1:0]       hist_raddr;
  logic [MASK_WIDTH-1:0] hist_rdata;

  logic                  word_nz;
  logic                  len_full;
  logic                  seq_last;
  logic                  cmp_eq;
  logic                  cmp_last;
  logic                  clr_last;
  logic                  out_load;
  logic [HA_W-1:0]       ptr_inc;
  logic [HA_W-1:0]       pos_dec;
  logic [HA_W-1:0]       pos_inc;
  logic [SEQ_W-1:0]      seq_inc;

  assign mask_ext   = {16'd0, in_data.button_mask};
  assign value_ext  = {16'd0, in_data.table_value};
  assign press_mask = mask_ext[MASK_WIDTH-1:0];
  assign table_word = value_ext[MASK_WIDTH-1:0];

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign slot_ok  = int'(in_data.table_slot) < NUM_SEQUENCES;
  assign press_go = in_fire && (in_data.req_type == REQ_PRESS) && in_data.stream_idle
                    && (press_mask != '0);

  assign word_nz  = (tbl_rdata != '0);
  assign len_full = (len_r == LEN_W'(SEQ_SLOTS - 1));
  assign seq_last = (seq_r == SEQ_W'(NUM_SEQUENCES - 1));
  assign cmp_eq   = (hist_rdata == tbl_rdata);
  assign cmp_last = ((LEN_W'(k_r) + LEN_W'(1)) == len_r);
  assign clr_last = (clr_cnt_r == TA_W'(TBL_DEPTH - 1));
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign ptr_inc = (ptr_r == HA_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_r + HA_W'(1);
  assign pos_dec = (pos_r == '0) ? HA_W'(HISTORY_DEPTH - 1) : pos_r - HA_W'(1);
  assign pos_inc = (pos_r == HA_W'(HISTORY_DEPTH - 1)) ? '0 : pos_r + HA_W'(1);
  assign seq_inc = seq_r + SEQ_W'(1);

  assign hist_we = press_go;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (press_go) begin
          state_nxt = ST_LEN;
        end else if (in_fire) begin
          state_nxt = ST_DONE;
        end
      end
      ST_LEN: begin
        if ((word_nz && len_full) || (!word_nz && (len_r != '0))) begin
          state_nxt = ST_CMP;
        end else if (!word_nz && seq_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_CMP: begin
        if (cmp_eq && cmp_last) begin
          state_nxt = ST_DONE;
        end else if (!cmp_eq) begin
          state_nxt = seq_last ? ST_DONE : ST_LEN;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_cnt_nxt     = clr_cnt_r;
    ptr_nxt         = ptr_r;
    pos_nxt         = pos_r;
    seq_nxt         = seq_r;
    len_nxt         = len_r;
    k_nxt           = k_r;
    res_matched_nxt = res_matched_r;
    res_index_nxt   = res_index_r;
    tbl_we          = 1'b0;
    tbl_waddr       = TA_W'({in_data.table_slot, in_data.table_position});
    tbl_wdata       = table_word;
    tbl_raddr       = TA_W'({seq_r, k_r});
    hist_raddr      = pos_r;
    hist_clr        = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        tbl_we      = 1'b1;
        tbl_waddr   = clr_cnt_r;
        tbl_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + TA_W'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          res_matched_nxt = 1'b0;
          res_index_nxt   = '0;
          tbl_we          = (in_data.req_type == REQ_WRITE) && slot_ok;
        end
        if (press_go) begin
          ptr_nxt   = ptr_inc;
          pos_nxt   = ptr_inc;
          seq_nxt   = '0;
          len_nxt   = '0;
          tbl_raddr = '0;
        end
      end
      ST_LEN: begin
        if (word_nz) begin
          len_nxt = len_r + LEN_W'(1);
          pos_nxt = pos_dec;
          if (len_full) begin
            k_nxt      = '0;
            tbl_raddr  = TA_W'({seq_r, SLOT_W'(0)});
            hist_raddr = pos_dec;
          end else begin
            tbl_raddr = TA_W'({seq_r, len_r[SLOT_W-1:0] + SLOT_W'(1)});
          end
        end else if (len_r != '0) begin
          k_nxt      = '0;
          tbl_raddr  = TA_W'({seq_r, SLOT_W'(0)});
          hist_raddr = pos_r;
        end else begin
          seq_nxt   = seq_inc;
          len_nxt   = '0;
          pos_nxt   = ptr_r;
          tbl_raddr = TA_W'({seq_inc, SLOT_W'(0)});
        end
      end
      ST_CMP: begin
        if (cmp_eq && cmp_last) begin
          hist_clr        = 1'b1;
          ptr_nxt         = '0;
          res_matched_nxt = 1'b1;
          res_index_nxt   = IDX_W'(seq_r);
        end else if (cmp_eq) begin
          k_nxt      = k_r + SLOT_W'(1);
          pos_nxt    = pos_inc;
          tbl_raddr  = TA_W'({seq_r, k_r + SLOT_W'(1)});
          hist_raddr = pos_inc;
        end else begin
          seq_nxt   = seq_inc;
          len_nxt   = '0;
          pos_nxt   = ptr_r;
          tbl_raddr = TA_W'({seq_inc, SLOT_W'(0)});
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.matched       = res_matched_r;
      out_data_nxt.matched_index = res_index_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    seq_r         <= seq_nxt;
    len_r         <= len_nxt;
    k_r           <= k_nxt;
    res_matched_r <= res_matched_nxt;
    res_index_r   <= res_index_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bsm_tbl_mem #(
    .DEPTH (TBL_DEPTH),
    .WIDTH (MASK_WIDTH)
  ) u_tbl_mem (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  bsm_hist_mem #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (MASK_WIDTH)
  ) u_hist_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (hist_clr),
    .we    (hist_we),
    .waddr (ptr_r),
    .wdata (press_mask),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  a_press_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    press_go |=> (state_r == ST_LEN) && (seq_r == '0) && (len_r == '0))
    else $error("A counted press did not start the walk at the first sequence.");

  a_match_resets_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) && cmp_eq && cmp_last |=> (ptr_r == '0) && res_matched_r)
    else $error("A match did not reset the history pointer.");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (len_r != '0) && (LEN_W'(k_r) < len_r))
    else $error("The compare index left the sequence length.");

endmodule

`default_nettype wire
